>>> hdl/uftc_pkg.sv
package uftc_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned SlotW      = $clog2(TableDepth);
  localparam int unsigned MaxProbe   = 8;
  localparam int unsigned ProbeW     = $clog2(MaxProbe + 1);

  localparam logic [3:0]  MinHdrWords = 4'd5;   // 20 bytes
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [15:0] GapReset    = 16'd10;
  localparam logic [31:0] HashMul     = 32'h045D9F3B;
  localparam logic [31:0] Sat32       = 32'hFFFF_FFFF;
  localparam logic [10:0] FlowMax     = 11'd2047;

  localparam logic [2:0] StBadHdr = 3'd0;
  localparam logic [2:0] StNotUdp = 3'd1;
  localparam logic [2:0] StExist  = 3'd2;
  localparam logic [2:0] StNew    = 3'd3;
  localparam logic [2:0] StFull   = 3'd4;

  localparam int unsigned RegGap = 0;

  typedef struct packed {
    logic [3:0]  header_len_words;
    logic [7:0]  ip_protocol;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        install_request;
    logic        first_attempt;
    logic [9:0]  flow_slot;
    logic [31:0] packet_count;
    logic [31:0] attempt_total;
    logic [31:0] install_total;
    logic [31:0] rule_source_addr;
    logic [31:0] rule_dest_addr;
    logic [15:0] rule_source_port;
    logic [15:0] rule_dest_port;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;     // clear one valid bit of the post-reset pass
    logic load;      // latch input item
    logic hash2;     // second hash step
    logic probe_rd;  // issue read of probe slot
    logic probe_chk; // evaluate returned slot
    logic commit;    // update entry and build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // clearing pass at its last slot
    logic early;     // bad header or not UDP
    logic done;      // probe search finished
  } dp_sts_t;

endpackage

>>> hdl/uftc_if.sv
interface uftc_in_if;
  import uftc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface uftc_out_if;
  import uftc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/uftc_datapath.sv
module uftc_datapath
  import uftc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   item_i,
  input  logic [15:0] gap_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  output out_item_t  res_o
);

  // table memories
  logic [63:0] mem_addrs [TableDepth];
  logic [31:0] mem_ports [TableDepth];
  logic [31:0] mem_count [TableDepth];
  logic        mem_att   [TableDepth];
  logic        mem_valid [TableDepth];
  logic [SlotW-1:0] clr_idx_q;

  in_item_t    it_q;
  logic [31:0] k_q;
  logic [SlotW-1:0] home_q, rd_slot_q, hit_slot_q, free_slot_q;
  logic [ProbeW-1:0] idx_q;
  logic        hit_q, have_free_q, rd_valid_q;
  logic [63:0] rd_addrs_q;
  logic [31:0] rd_ports_q, rd_count_q;
  logic        rd_att_q;
  logic [31:0] last_q, att_tot_q, ins_tot_q;
  logic [10:0] flow_tot_q;
  out_item_t   res_q;

  logic [31:0] k0, k1, k2;
  logic [63:0] key_addrs;
  logic [31:0] key_ports;
  logic        early;

  assign key_addrs = {it_q.source_addr, it_q.dest_addr};
  assign key_ports = {it_q.source_port, it_q.dest_port};
  assign early = (it_q.header_len_words < MinHdrWords) || (it_q.ip_protocol != ProtoUdp);

  // hash: first step at load (xor+mult), second step after
  always_comb begin
    k0 = item_i.source_addr ^ item_i.dest_addr ^ {item_i.source_port, item_i.dest_port};
    k0 = k0 ^ (k0 >> 16);
    k1 = k0 * HashMul;
    k2 = k_q ^ (k_q >> 16);
  end

  assign sts_o.early    = early;
  assign sts_o.done     = (idx_q == ProbeW'(MaxProbe)) || hit_q;
  assign sts_o.clr_last = (clr_idx_q == SlotW'(TableDepth - 1));

  // probe bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      hit_q       <= 1'b0;
      have_free_q <= 1'b0;
      clr_idx_q   <= '0;
      last_q      <= '0;
      att_tot_q   <= '0;
      ins_tot_q   <= '0;
      flow_tot_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (cmd_i.load) begin
        idx_q       <= '0;
        hit_q       <= 1'b0;
        have_free_q <= 1'b0;
      end
      if (cmd_i.probe_chk) begin
        idx_q <= idx_q + 1'b1;
        if (rd_valid_q) begin
          if (rd_addrs_q == key_addrs && rd_ports_q == key_ports) begin
            hit_q <= 1'b1;
          end
        end else if (!have_free_q) begin
          have_free_q <= 1'b1;
        end
      end
      if (cmd_i.commit && !early && (hit_q || have_free_q)) begin
        if (!hit_q) begin
          if (flow_tot_q != FlowMax) flow_tot_q <= flow_tot_q + 1'b1;
        end
        if (!hit_q || !rd_att_q) begin
          if (att_tot_q != Sat32) att_tot_q <= att_tot_q + 1'b1;
          if ((it_q.now_ms - last_q) > {16'd0, gap_i}) begin
            if (ins_tot_q != Sat32) ins_tot_q <= ins_tot_q + 1'b1;
            last_q <= it_q.now_ms;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q <= item_i;
      k_q  <= k1;
    end
    if (cmd_i.hash2) begin
      home_q <= k2[SlotW-1:0];
    end
    if (cmd_i.probe_rd) begin
      rd_slot_q <= home_q + SlotW'(idx_q);
    end
    if (cmd_i.probe_chk) begin
      if (rd_valid_q) begin
        if (rd_addrs_q == key_addrs && rd_ports_q == key_ports) begin
          hit_slot_q <= rd_slot_q;
        end
      end else if (!have_free_q) begin
        free_slot_q <= rd_slot_q;
      end
    end
  end

  // table read port (registered), keep last read for hit slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_rd) begin
      rd_valid_q <= mem_valid[home_q + SlotW'(idx_q)];
      rd_addrs_q <= mem_addrs[home_q + SlotW'(idx_q)];
      rd_ports_q <= mem_ports[home_q + SlotW'(idx_q)];
      rd_count_q <= mem_count[home_q + SlotW'(idx_q)];
      rd_att_q   <= mem_att[home_q + SlotW'(idx_q)];
    end
  end

  // table write port and result build
  logic [SlotW-1:0] slot;
  logic [31:0]      cnt_new;
  logic             first;
  logic             ins;
  out_item_t        res_d;
  always_comb begin
    slot    = hit_q ? hit_slot_q : free_slot_q;
    cnt_new = hit_q ? ((rd_count_q == Sat32) ? rd_count_q : rd_count_q + 32'd1) : 32'd1;
    first   = !hit_q || !rd_att_q;
    ins     = first && ((it_q.now_ms - last_q) > {16'd0, gap_i});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_valid[clr_idx_q] <= 1'b0;
    end else if (cmd_i.commit && !early && !hit_q && have_free_q) begin
      mem_valid[free_slot_q] <= 1'b1;
    end
    if (cmd_i.commit && !early && (hit_q || have_free_q)) begin
      mem_count[slot] <= cnt_new;
      mem_att[slot]   <= 1'b1;
      if (!hit_q) begin
        mem_addrs[slot] <= key_addrs;
        mem_ports[slot] <= key_ports;
      end
    end
  end

  always_comb begin
    res_d = '0;
    res_d.attempt_total = att_tot_q;
    res_d.install_total = ins_tot_q;
    if (it_q.header_len_words < MinHdrWords) begin
      res_d.status = StBadHdr;
    end else if (it_q.ip_protocol != ProtoUdp) begin
      res_d.status = StNotUdp;
    end else if (!hit_q && !have_free_q) begin
      res_d.status = StFull;
    end else begin
      res_d.status          = hit_q ? StExist : StNew;
      res_d.flow_slot       = 10'(slot);
      res_d.packet_count    = cnt_new;
      res_d.first_attempt   = first;
      res_d.install_request = ins;
      if (first) begin
        res_d.attempt_total = (att_tot_q == Sat32) ? att_tot_q : att_tot_q + 32'd1;
      end
      if (ins) begin
        res_d.install_total    = (ins_tot_q == Sat32) ? ins_tot_q : ins_tot_q + 32'd1;
        res_d.rule_source_addr = it_q.source_addr;
        res_d.rule_dest_addr   = it_q.dest_addr;
        res_d.rule_source_port = it_q.source_port;
        res_d.rule_dest_port   = it_q.dest_port;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  // probe index stays within the probe window
  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q <= ProbeW'(MaxProbe))
    else $error("probe index overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !early && !hit_q && have_free_q |=> flow_tot_q != '0)
    else $error("inserted flow not counted");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> idx_q == '0 && !hit_q && !have_free_q)
    else $error("probe state not cleared");

endmodule

>>> hdl/uftc_ctrl.sv
module uftc_ctrl
  import uftc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;

  // a new item may be taken while the result waits, commit waits for room
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.clear     = (state_q == S_CLEAR);
    cmd_o.load      = in_valid_i && in_ready_o;
    cmd_o.hash2     = (state_q == S_HASH);
    cmd_o.probe_rd  = (state_q == S_READ);
    cmd_o.probe_chk = (state_q == S_CHECK);
    cmd_o.commit    = (state_q == S_COMMIT) && (sts_i.early || sts_i.done) &&
                      (!out_valid_q || out_ready_i);
  end

  // result valid: set by commit, cleared by an output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_CLEAR:  if (sts_i.clr_last) state_q <= S_IDLE;
        S_IDLE:   if (in_valid_i) state_q <= S_HASH;
        S_HASH:   state_q <= sts_i.early ? S_COMMIT : S_READ;
        S_READ:   state_q <= S_CHECK;
        S_CHECK:  state_q <= S_COMMIT;
        S_COMMIT: begin
          if (!sts_i.early && !sts_i.done) begin
            state_q <= S_READ;
          end else if (cmd_o.commit) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit without result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.commit))
    else $error("load during commit");

endmodule

>>> hdl/udp_flow_table_counter_top.sv
// UDP flow table with packet counters.
// Input channel in_if carries one header summary per transfer; output channel
// out_if returns exactly one result per input transfer, in order.
// An APB port holds install_gap_ms at address 0 (reset 10); write it only
// while the block is idle.
// Bad-header and non-UDP items pass through S_HASH and S_COMMIT, and the result
// is registered at commit. UDP items take a hash step, then a read, compare
// and decide step per probed slot until a hit or MaxProbe slots are seen.
// The block works on one item at a time, set by the sequential probe: the next
// input transfer can come in the cycle after the result is registered.
// After reset a clearing pass walks the valid bits of all 1024 slots, one per
// cycle; in_if.ready stays low until the pass is done.
// The result register holds one finished item; the next item is accepted
// while it waits, and its commit stalls until the receiver takes the first.
module udp_flow_table_counter_top
  import uftc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  uftc_in_if.sink     in_if,
  uftc_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] gap_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'(RegGap * 4)) ? {16'd0, gap_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GapReset;
    end else if (psel && penable && pwrite && paddr == 2'(RegGap * 4)) begin
      gap_q <= pwdata[15:0];
    end
  end

  uftc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  uftc_datapath u_dp (
    .clk_i,
    .rst_ni,
    .item_i (in_if.data),
    .gap_i  (gap_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (out_if.data)
  );

endmodule
